### hw/rtl/fmss_pkg.sv
// Shared types, constants and helpers for the frame mean-square signature block.
// No dependencies; imported by every module of the block.
`default_nettype none

package fmss_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned SQ_W     = 18;  // r*r + g*g + b*b, max 195075
  localparam int unsigned SUM_W    = 42;
  localparam int unsigned NUM_W    = 49;  // SUM_W bits times 100
  localparam int unsigned DEN_W    = 25;  // width * height, max 2^24
  localparam int unsigned SIG_W    = 25;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(4096);
  localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(1);
  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1080);
  localparam logic [SIG_W-1:0] SIG_MAX   = SIG_W'(19507500);

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  // Frame-end job queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = Q_PTR_W + 1;

  // Restoring divider, one quotient bit per cycle
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_MIN;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/frame_mean_square_signature_core.sv
// Frame mean-square signature: one pixel per cycle in (unless stalled), one signature
// per frame out. Path from the last pixel to signature valid: square stage, queue,
// scale, bit-serial divider, saturation; pixels sustain 1 per cycle unless stalled.
// The divider takes one frame end at a time; two pending frame ends are queued.
// Reset (async, active low) clears the sum, queue and control; width 1920, height 1080.
`default_nettype none

module frame_mean_square_signature_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fmss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [fmss_pkg::DIM_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [fmss_pkg::PIX_W-1:0]     red_i,
  input  wire logic [fmss_pkg::PIX_W-1:0]     green_i,
  input  wire logic [fmss_pkg::PIX_W-1:0]     blue_i,
  input  wire logic                           last_pixel_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [fmss_pkg::SIG_W-1:0]     signature_o
);
  import fmss_pkg::*;

  logic [DIM_W-1:0] width_q, width_d;
  logic [DIM_W-1:0] height_q, height_d;
  logic             push, pop;
  job_t             push_job, head_job;
  q_status_t        q_status;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  width_d  = cfg_data_i;
        REG_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  fmss_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .red_i,
    .green_i,
    .blue_i,
    .last_pixel_i,
    .width_i    (width_q),
    .height_i   (height_q),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  fmss_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .status_o    (q_status)
  );

  fmss_back u_back (
    .clk_i,
    .rst_ni,
    .q_status_i (q_status),
    .job_i      (head_job),
    .pop_o      (pop),
    .out_valid_o,
    .out_stall_i,
    .signature_o
  );

endmodule

`default_nettype wire

### hw/rtl/fmss_front.sv
// Front end: takes pixels, squares and accumulates them, queues a job per frame.
// Depends on fmss_pkg.
`default_nettype none

module fmss_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire logic [fmss_pkg::PIX_W-1:0] red_i,
  input  wire logic [fmss_pkg::PIX_W-1:0] green_i,
  input  wire logic [fmss_pkg::PIX_W-1:0] blue_i,
  input  wire logic                       last_pixel_i,
  input  wire logic [fmss_pkg::DIM_W-1:0] width_i,
  input  wire logic [fmss_pkg::DIM_W-1:0] height_i,
  input  wire fmss_pkg::q_status_t        q_status_i,
  output      logic                       push_o,
  output      fmss_pkg::job_t             job_o
);
  import fmss_pkg::*;

  logic              a_vld_q, a_vld_d;
  logic              a_last_q, a_last_d;
  logic [SQ_W-1:0]   a_add_q, a_add_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [2*PIX_W-1:0] rr, gg, bb;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;
  logic              accept, consume;

  assign in_stall_o = a_vld_q & a_last_q & q_status_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign consume    = a_vld_q & (~a_last_q | ~q_status_i.full);

  assign rr = red_i * red_i;
  assign gg = green_i * green_i;
  assign bb = blue_i * blue_i;

  // saturating accumulate of the registered square sum
  assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(a_add_q);
  assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

  always_comb begin
    a_add_d  = a_add_q;
    a_last_d = a_last_q;
    a_vld_d  = a_vld_q;
    sum_d    = sum_q;
    if (consume) begin
      a_vld_d = 1'b0;
      sum_d   = a_last_q ? '0 : sum_sat;
    end
    if (accept) begin
      a_vld_d  = 1'b1;
      a_last_d = last_pixel_i;
      a_add_d  = SQ_W'(rr) + SQ_W'(gg) + SQ_W'(bb);
    end
  end

  assign push_o       = consume & a_last_q;
  assign job_o.sum    = sum_sat;
  assign job_o.width  = clamp_dim(width_i);
  assign job_o.height = clamp_dim(height_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      sum_q   <= '0;
    end else begin
      a_vld_q <= a_vld_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_last_q <= a_last_d;
    a_add_q  <= a_add_d;
  end

`ifndef SYNTHESIS
  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_status_i.full)
    else $error("front pushed into a full queue");

  a_sum_cleared_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (sum_q == '0))
    else $error("energy sum not cleared after frame end");

  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (a_vld_q && a_last_q))
    else $error("front stalled without a pending frame end");
`endif

endmodule

`default_nettype wire

### hw/rtl/fmss_queue.sv
// Two-entry job queue decoupling the pixel front end from the divider back end.
// Depends on fmss_pkg.
`default_nettype none

module fmss_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire fmss_pkg::job_t       push_data_i,
  input  wire logic                 pop_i,
  output      fmss_pkg::job_t       head_o,
  output      fmss_pkg::q_status_t  status_o
);
  import fmss_pkg::*;

  job_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  // depth is a power of two, pointers wrap naturally
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + Q_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + Q_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("queue underflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

### hw/rtl/fmss_back.sv
// Back end: scales the frame sum by 100, divides by width*height bit-serially,
// saturates and holds the result in the output register. Depends on fmss_pkg.
`default_nettype none

module fmss_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire fmss_pkg::q_status_t        q_status_i,
  input  wire fmss_pkg::job_t             job_i,
  output      logic                       pop_o,
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic [fmss_pkg::SIG_W-1:0] signature_o
);
  import fmss_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic [DEN_W-1:0]     den_q, den_d;
  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [DIM_W-1:0]     w_q, w_d;
  logic [DIM_W-1:0]     h_q, h_d;
  logic                 out_vld_q, out_vld_d;
  logic [SIG_W-1:0]     sig_q, sig_d;
  logic [2*DIM_W-1:0]   area;
  logic [NUM_W-1:0]     num_ext;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_sub;
  logic                 ge;
  logic                 out_free;

  assign out_free = ~out_vld_q | ~out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) & ~q_status_i.empty;

  assign area    = w_q * h_q;
  assign num_ext = num_q;
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    num_d     = num_q;
    den_d     = den_q;
    rem_d     = rem_q;
    w_d       = w_q;
    h_d       = h_q;
    sig_d     = sig_q;
    out_vld_d = out_vld_q & out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          num_d   = NUM_W'(job_i.sum);
          w_d     = job_i.width;
          h_d     = job_i.height;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        // x*100 = x*64 + x*32 + x*4
        num_d   = (num_ext << 6) + (num_ext << 5) + (num_ext << 2);
        den_d   = area[DEN_W-1:0];
        rem_d   = '0;
        cnt_d   = DIV_CNT_W'(DIV_STEPS - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        num_d = {num_q[NUM_W-2:0], ge};
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q - DIV_CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (out_free) begin
          sig_d     = (num_q > NUM_W'(SIG_MAX)) ? SIG_MAX : num_q[SIG_W-1:0];
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    w_q   <= w_d;
    h_q   <= h_d;
    sig_q <= sig_d;
  end

  assign out_valid_o = out_vld_q;
  assign signature_o = sig_q;

`ifndef SYNTHESIS
  a_sig_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (sig_q <= SIG_MAX))
    else $error("signature above saturation limit");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q != '0) |=> (state_q == ST_DIV))
    else $error("divider left early");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < den_q))
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

### tb/sv/fmss_signature_checker.sv
// Scoreboard for frame_mean_square_signature_core: tracks register writes and pixel
// transfers, predicts one signature per frame end and compares it with the results.
// Depends on fmss_pkg for port widths and register indexes.
module fmss_signature_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fmss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fmss_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [fmss_pkg::PIX_W-1:0]     red_i,
  input  logic [fmss_pkg::PIX_W-1:0]     green_i,
  input  logic [fmss_pkg::PIX_W-1:0]     blue_i,
  input  logic                           last_pixel_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [fmss_pkg::SIG_W-1:0]     signature_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned SCALE          = 100;
  localparam longint unsigned SIGNATURE_CEIL = 19507500;
  localparam longint unsigned DIM_CEIL       = 4096;
  localparam longint unsigned ENERGY_CEIL    = (64'd1 << 42) - 64'd1;
  localparam logic [fmss_pkg::DIM_W-1:0] WIDTH_AT_RESET  = 13'd1920;
  localparam logic [fmss_pkg::DIM_W-1:0] HEIGHT_AT_RESET = 13'd1080;
  localparam int unsigned REPORT_LIMIT = 10;

  logic [fmss_pkg::DIM_W-1:0] width_setting  = WIDTH_AT_RESET;
  logic [fmss_pkg::DIM_W-1:0] height_setting = HEIGHT_AT_RESET;
  longint unsigned            energy_total   = 0;
  logic [fmss_pkg::SIG_W-1:0] expected_signatures[$];
  int unsigned                mismatches     = 0;
  int unsigned                pending        = 0;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = pending;

  // zero reads as one, anything past 4096 as 4096
  function automatic longint unsigned effective_dim(input logic [fmss_pkg::DIM_W-1:0] v);
    if (v == '0) return 64'd1;
    if (64'(v) > DIM_CEIL) return DIM_CEIL;
    return 64'(v);
  endfunction

  function automatic longint unsigned pixel_energy(input logic [fmss_pkg::PIX_W-1:0] r,
                                                   input logic [fmss_pkg::PIX_W-1:0] g,
                                                   input logic [fmss_pkg::PIX_W-1:0] b);
    return 64'(r) * 64'(r) + 64'(g) * 64'(g) + 64'(b) * 64'(b);
  endfunction

  function automatic logic [fmss_pkg::SIG_W-1:0] frame_signature(
      input longint unsigned energy, input logic [fmss_pkg::DIM_W-1:0] w,
      input logic [fmss_pkg::DIM_W-1:0] h);
    longint unsigned quotient;
    quotient = (energy * SCALE) / (effective_dim(w) * effective_dim(h));
    if (quotient > SIGNATURE_CEIL) quotient = SIGNATURE_CEIL;
    return fmss_pkg::SIG_W'(quotient);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : observe
    longint unsigned          added;
    logic [fmss_pkg::SIG_W-1:0] wanted;
    if (!rst_ni) begin
      width_setting  = WIDTH_AT_RESET;
      height_setting = HEIGHT_AT_RESET;
      energy_total   = 0;
      expected_signatures.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fmss_pkg::REG_WIDTH: begin
            width_setting = cfg_data_i;
          end
          fmss_pkg::REG_HEIGHT: begin
            height_setting = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_signatures.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: signature %0d transferred with none pending", $realtime, signature_i);
        end else begin
          wanted = expected_signatures.pop_front();
          if (signature_i !== wanted) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: signature mismatch: expected %0d, got %0d",
                       $realtime, wanted, signature_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        added = pixel_energy(red_i, green_i, blue_i);
        // running sum sticks at its ceiling instead of wrapping
        if (energy_total > ENERGY_CEIL - added) energy_total = ENERGY_CEIL;
        else energy_total += added;
        if (last_pixel_i) begin
          wanted = frame_signature(energy_total, width_setting, height_setting);
          expected_signatures.insert(expected_signatures.size(), wanted);
          energy_total = 0;
        end
      end
    end
    pending = expected_signatures.size();
  end

endmodule

### tb/sv/tb_frame_mean_square_signature_core.sv
// Top of the frame_mean_square_signature_core testbench: clock, reset, register
// writes, pixel and result traffic with idle and stall phases, and the verdict.
// Depends on fmss_pkg, the core and fmss_signature_checker.
module tb_frame_mean_square_signature_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HALF_PERIOD      = 4;
  localparam int unsigned RESET_CYCLES     = 5;
  localparam int unsigned DRAIN_CYCLES     = 80;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned PHASES           = 10;
  localparam int unsigned PIXELS_PER_PHASE = 200;
  localparam int unsigned PRESSURE_PHASE   = 7;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam logic [fmss_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [fmss_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;
  localparam logic [fmss_pkg::PIX_W-1:0]     FULL_SCALE   = 8'hFF;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [fmss_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [fmss_pkg::DIM_W-1:0]     cfg_data_i;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [fmss_pkg::PIX_W-1:0]     red_i;
  logic [fmss_pkg::PIX_W-1:0]     green_i;
  logic [fmss_pkg::PIX_W-1:0]     blue_i;
  logic                           last_pixel_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [fmss_pkg::SIG_W-1:0]     signature_o;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_request       = 0;

  frame_mean_square_signature_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .last_pixel_i (last_pixel_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .signature_o  (signature_o)
  );

  fmss_signature_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .last_pixel_i     (last_pixel_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .signature_i      (signature_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  // result side: random stalls, or one long hold-off when requested
  initial begin : receiver
    int unsigned held;
    held        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        held         = hold_request;
        hold_request = 0;
      end
      if (held != 0) begin
        out_stall_i = 1'b1;
        held--;
      end else begin
        out_stall_i = ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  // ends the run when no transfer happens on either channel for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("frame_mean_square_signature_core verification failed");
    $finish;
  end

  function automatic logic [fmss_pkg::PIX_W-1:0] random_channel();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) return FULL_SCALE;
    if (pick < 28) return '0;
    return fmss_pkg::PIX_W'($urandom);
  endfunction

  function automatic int unsigned frame_area(input logic [fmss_pkg::DIM_W-1:0] w,
                                             input logic [fmss_pkg::DIM_W-1:0] h);
    int unsigned wu, hu;
    wu = (w == '0) ? 1 : ((w > 13'd4096) ? 4096 : int'(w));
    hu = (h == '0) ? 1 : ((h > 13'd4096) ? 4096 : int'(h));
    return wu * hu;
  endfunction

  // called at a falling edge; valid stays high on return so transfers run back to back
  task automatic send_pixel(input logic [fmss_pkg::PIX_W-1:0] r,
                            input logic [fmss_pkg::PIX_W-1:0] g,
                            input logic [fmss_pkg::PIX_W-1:0] b, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    red_i        = r;
    green_i      = g;
    blue_i       = b;
    last_pixel_i = last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int unsigned length, input logic bright, input logic closes);
    for (int unsigned i = 0; i < length; i++) begin
      if (bright) send_pixel(FULL_SCALE, FULL_SCALE, FULL_SCALE, closes && (i == length - 1));
      else send_pixel(random_channel(), random_channel(), random_channel(),
                      closes && (i == length - 1));
    end
  endtask

  task automatic wait_until_idle();
    in_valid_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [fmss_pkg::CFG_IDX_W-1:0] idx,
                                input logic [fmss_pkg::DIM_W-1:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic set_dimensions(input logic [fmss_pkg::DIM_W-1:0] w,
                                input logic [fmss_pkg::DIM_W-1:0] h);
    wait_until_idle();
    write_register(fmss_pkg::REG_WIDTH, w);
    write_register(fmss_pkg::REG_HEIGHT, h);
  endtask

  initial begin : stimulus
    logic [fmss_pkg::DIM_W-1:0] width_pick, height_pick;
    int unsigned area, length, phase_pixels, pick;
    logic bright;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = fmss_pkg::REG_WIDTH;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    red_i        = '0;
    green_i      = '0;
    blue_i       = '0;
    last_pixel_i = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset dimensions: single-pixel frames, dark and fully bright
    send_pixel('0, '0, '0, 1'b1);
    send_pixel(FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b1);
    // 1x1: exact ceiling, small value, overfull frame that must saturate
    set_dimensions(13'd1, 13'd1);
    send_pixel(FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b1);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b1);
    send_pixel(FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b0);
    send_pixel(FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b1);
    send_pixel(8'd128, 8'd64, 8'd32, 1'b1);
    // zero and oversized register values, writes to unmapped indexes
    set_dimensions(13'd0, 13'h1FFF);
    write_register(REG_UNUSED_A, 13'h1FFF);
    write_register(REG_UNUSED_B, 13'h0AAA);
    send_pixel(FULL_SCALE, '0, '0, 1'b0);
    send_pixel('0, FULL_SCALE, '0, 1'b0);
    send_pixel('0, '0, FULL_SCALE, 1'b1);
    // dimensions change while a frame is open
    send_pixel(8'd170, 8'd85, 8'd1, 1'b0);
    set_dimensions(13'd4096, 13'd1);
    send_pixel(8'd85, 8'd170, 8'd254, 1'b1);
    set_dimensions(13'd4096, 13'd4096);
    send_pixel(FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b1);
    set_dimensions(13'h1FFF, 13'd0);
    send_pixel(8'd127, 8'd128, FULL_SCALE, 1'b1);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin width_pick = 13'd1;    height_pick = 13'd1;    end
        1: begin width_pick = 13'd4;    height_pick = 13'd3;    end
        2: begin width_pick = 13'd0;    height_pick = 13'd0;    end
        3: begin width_pick = 13'd4096; height_pick = 13'd4096; end
        4: begin width_pick = 13'h1FFF; height_pick = 13'h1FFF; end
        5: begin width_pick = 13'd7;    height_pick = 13'd5;    end
        6: begin
          width_pick  = 13'($urandom_range(8, 1));
          height_pick = 13'($urandom_range(8, 1));
        end
        7: begin width_pick = 13'd2;    height_pick = 13'd1;    end
        8: begin width_pick = 13'd5000; height_pick = 13'd2;    end
        default: begin width_pick = 13'd8; height_pick = 13'd8; end
      endcase
      set_dimensions(width_pick, height_pick);
      write_register(REG_UNUSED_A, 13'($urandom));
      write_register(REG_UNUSED_B, 13'($urandom));
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
        default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
      endcase
      // long hold-off on results while pixels keep coming, so the core backs up
      if (phase == PRESSURE_PHASE) hold_request = HOLD_CYCLES;
      area         = frame_area(width_pick, height_pick);
      phase_pixels = 0;
      while (phase_pixels < PIXELS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (area > 64) length = $urandom_range(16, 1);
        else if (pick < 60) length = area;
        else if (pick < 75) length = area + $urandom_range(3, 1);
        else length = $urandom_range(2 * area, 1);
        bright = ($urandom_range(99) < 15);
        send_frame(length, bright, 1'b1);
        phase_pixels += length;
      end
      // sometimes leave a frame open across the next register change
      if ($urandom_range(1) == 1) send_frame($urandom_range(3, 1), 1'b0, 1'b0);
    end

    wait_until_idle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("frame_mean_square_signature_core verification clean");
    end else begin
      $display("frame_mean_square_signature_core verification failed");
    end
    $finish;
  end

endmodule

### frame_mean_square_signature_core.f
hw/rtl/fmss_pkg.sv
hw/rtl/fmss_front.sv
hw/rtl/fmss_queue.sv
hw/rtl/fmss_back.sv
hw/rtl/frame_mean_square_signature_core.sv
tb/sv/fmss_signature_checker.sv
tb/sv/tb_frame_mean_square_signature_core.sv
